[hw/rtl/lge_pkg.sv]
// ----------------------------------------------------------------------------
// lge_pkg: shared definitions for the life grid generation engine
// Grid sizes, field widths, request and register codes, and control structs.
// ----------------------------------------------------------------------------
package lge_pkg;

	// Grid storage size.
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;

	// Field widths fixed by the request and register formats.
	localparam int POS_W  = 6;
	localparam int TYPE_W = 2;
	localparam int CFG_W  = 7;
	localparam int CIDX_W = 1;

	// Derived internal widths.
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int SCNT_W = $clog2(MAX_ROWS + 3);

	// Size register value after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Lag between reading a row and writing it back during a step.
	localparam int STEP_LAG = 3;

	// Neighborhood totals that include the center cell.
	localparam logic [3:0] BIRTH_SUM   = 4'd3;
	localparam logic [3:0] SURVIVE_SUM = 4'd4;

	typedef enum logic [TYPE_W-1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_STEP  = 2'd2
	} req_type_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_COLS = 1'b0,
		CFG_ROWS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} lge_cell_ctl_t;

	typedef struct packed {
		logic rd_en;
		logic rd_zero;
		logic wr_en;
	} lge_store_ctl_t;

	function automatic logic [CCNT_W-1:0] clip_cols(input logic [CFG_W-1:0] v);
		if (int'(v) > MAX_COLS) begin
			return CCNT_W'(MAX_COLS);
		end
		return CCNT_W'(v);
	endfunction

	function automatic logic [RCNT_W-1:0] clip_rows(input logic [CFG_W-1:0] v);
		if (int'(v) > MAX_ROWS) begin
			return RCNT_W'(MAX_ROWS);
		end
		return RCNT_W'(v);
	endfunction

endpackage

[hw/rtl/lge_req_if.sv]
// ----------------------------------------------------------------------------
// lge_req_if: request channel
// Valid/ready channel that carries one cell access or generation request.
// ----------------------------------------------------------------------------
interface lge_req_if;
	logic                      valid;
	logic                      ready;
	logic [lge_pkg::TYPE_W-1:0] req_type;
	logic [lge_pkg::POS_W-1:0]  col_pos;
	logic [lge_pkg::POS_W-1:0]  row_pos;
	logic                      alive_in;

	modport source (output valid, output req_type, output col_pos, output row_pos,
		output alive_in, input ready);
	modport sink (input valid, input req_type, input col_pos, input row_pos,
		input alive_in, output ready);
endinterface

[hw/rtl/lge_rsp_if.sv]
// ----------------------------------------------------------------------------
// lge_rsp_if: response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface lge_rsp_if;
	logic valid;
	logic ready;
	logic alive_out;
	logic out_of_range;

	modport source (output valid, output alive_out, output out_of_range, input ready);
	modport sink (input valid, input alive_out, input out_of_range, output ready);
endinterface

[hw/rtl/lge_cell.sv]
// ----------------------------------------------------------------------------
// lge_cell: one column of the generation sweep
// Holds a three-row window of its column and applies the B3/S23 rule using
// the vertical sums handed over by its two neighbors.
// ----------------------------------------------------------------------------
module lge_cell (
	input  logic                   clk,
	input  lge_pkg::lge_cell_ctl_t ctl,
	input  logic                   in_use,
	input  logic                   bit_in,
	input  logic [1:0]             vsum_left,
	input  logic [1:0]             vsum_right,
	output logic [1:0]             vsum,
	output logic                   next_bit
);
	import lge_pkg::*;

	logic       above_q;
	logic       cur_q;
	logic       ctr_q;
	logic [1:0] vsum_q;
	logic [1:0] col_sum;
	logic [3:0] total;

	assign col_sum = {1'b0, above_q} + {1'b0, cur_q} + {1'b0, bit_in};

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			above_q <= 1'b0;
			cur_q   <= 1'b0;
		end else if (ctl.shift) begin
			above_q <= cur_q;
			cur_q   <= bit_in;
			ctr_q   <= cur_q;
			vsum_q  <= in_use ? col_sum : 2'd0;
		end
	end

	// The total includes the center cell itself, so a survivor shows three or four.
	assign total = {2'b00, vsum_left} + {2'b00, vsum_q} + {2'b00, vsum_right};

	assign vsum     = vsum_q;
	assign next_bit = in_use ? ((total == BIRTH_SUM) || (ctr_q && (total == SURVIVE_SUM)))
		: ctr_q;

endmodule

[hw/rtl/lge_store.sv]
// ----------------------------------------------------------------------------
// lge_store: grid row memory
// One row per entry, one write and one registered read port. Rows never
// written read as all dead through a valid bit per row.
// ----------------------------------------------------------------------------
module lge_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lge_pkg::lge_store_ctl_t       ctl,
	input  logic [lge_pkg::ROW_W-1:0]     rd_addr,
	input  logic [lge_pkg::ROW_W-1:0]     wr_addr,
	input  logic [lge_pkg::MAX_COLS-1:0]  wr_data,
	output logic [lge_pkg::MAX_COLS-1:0]  rd_data
);
	import lge_pkg::*;

	logic [MAX_COLS-1:0] mem [MAX_ROWS];
	logic [MAX_COLS-1:0] mem_q;
	logic [MAX_ROWS-1:0] vld_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr] && !ctl.rd_zero;
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_q : '0;

endmodule

[hw/rtl/life_grid_generation_engine_unit.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit: Conway life grid engine (B3/S23)
// Holds a grid of live and dead cells, serves single-cell reads and writes and
// advances the whole grid in use by one generation on request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (valid/ready); every request produces
//   exactly one transfer on the rsp channel. A read returns the cell and an
//   out-of-range flag; a write updates the cell unless the coordinate lies
//   outside the grid in use; a step advances every cell in the grid in use.
//   The grid size registers are written through cfg_we/cfg_idx/cfg_data while
//   no request is in flight; values above the storage size count as the
//   storage size, and zero means an empty grid.
// Sequencing:
//   A read or write is a read-modify-write of one row in the row memory: the
//   request transfer reads the row, and the RMW state writes it back and
//   registers the response; the next request is taken back in idle. A step
//   sweeps the rows through the row of column cells, reading one row and
//   writing back one row per cycle; the response is registered at the end
//   of the sweep, and the next request is taken back in idle. A step on an
//   empty grid and unused request codes go straight to the done state.
// Reset and stalls:
//   Reset makes every cell dead and sets both size registers to 64. No
//   clearing pass is needed. A request is taken while the previous response
//   still waits in the output register; if the receiver stalls, the finished
//   result is parked and the engine holds until the output register frees.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lge_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [lge_pkg::CFG_W-1:0]   cfg_data,
	lge_req_if.sink                     req,
	lge_rsp_if.source                   rsp
);
	import lge_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RMW,
		S_STEP,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    grid_cols_q;
	logic [CFG_W-1:0]    grid_rows_q;
	logic [CCNT_W-1:0]   ncols;
	logic [RCNT_W-1:0]   nrows;

	// Request fields held for the read-modify-write cycle.
	logic [TYPE_W-1:0]   type_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic                alive_q;
	logic                inside_q;

	logic [SCNT_W-1:0]   step_cnt_q;
	logic                res_alive_q;
	logic                res_oor_q;
	logic                rsp_valid_q;
	logic                rsp_alive_q;
	logic                rsp_oor_q;

	logic                accept;
	logic                in_grid;
	logic                out_free;
	logic                fin;
	logic                fin_alive;
	logic                fin_oor;
	logic                empty_grid;

	lge_store_ctl_t      store_ctl;
	lge_cell_ctl_t       cell_ctl;
	logic [ROW_W-1:0]    rd_addr;
	logic [ROW_W-1:0]    wr_addr;
	logic [MAX_COLS-1:0] wr_data;
	logic [MAX_COLS-1:0] rd_data;
	logic [MAX_COLS-1:0] rmw_row;
	logic [MAX_COLS-1:0] next_row;
	logic [MAX_COLS-1:0] col_in_use;
	logic [1:0]          vsum [MAX_COLS];

	// Size registers; the grid in use is clipped to the storage size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= CFG_RESET;
			grid_rows_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_COLS: grid_cols_q <= cfg_data;
				CFG_ROWS: grid_rows_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	assign ncols      = clip_cols(grid_cols_q);
	assign nrows      = clip_rows(grid_rows_q);
	assign empty_grid = (ncols == '0) || (nrows == '0);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_grid   = (int'(req.col_pos) < int'(ncols)) && (int'(req.row_pos) < int'(nrows));
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Result of the request that finishes in this cycle, if any.
	always_comb begin
		fin       = 1'b0;
		fin_alive = 1'b0;
		fin_oor   = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_RMW: begin
				fin       = 1'b1;
				fin_alive = (type_q == REQ_READ) && inside_q && rd_data[col_q];
				fin_oor   = !inside_q;
			end
			S_STEP: begin
				fin = (int'(step_cnt_q) == int'(nrows) + STEP_LAG - 1);
			end
			S_DONE: begin
				fin       = 1'b1;
				fin_alive = res_alive_q;
				fin_oor   = res_oor_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			type_q      <= '0;
			col_q       <= '0;
			alive_q     <= 1'b0;
			inside_q    <= 1'b0;
			step_cnt_q  <= '0;
			res_alive_q <= 1'b0;
			res_oor_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_alive_q <= 1'b0;
			rsp_oor_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (accept) begin
				type_q   <= req.req_type;
				col_q    <= COL_W'(req.col_pos);
				alive_q  <= req.alive_in;
				inside_q <= in_grid;
				unique case (req.req_type)
					REQ_WRITE, REQ_READ: begin
						state_q <= S_RMW;
					end
					REQ_STEP: begin
						step_cnt_q  <= '0;
						res_alive_q <= 1'b0;
						res_oor_q   <= 1'b0;
						state_q     <= empty_grid ? S_DONE : S_STEP;
					end
					default: begin
						res_alive_q <= 1'b0;
						res_oor_q   <= 1'b0;
						state_q     <= S_DONE;
					end
				endcase
			end else if (fin) begin
				if (out_free) begin
					rsp_valid_q <= 1'b1;
					rsp_alive_q <= fin_alive;
					rsp_oor_q   <= fin_oor;
					state_q     <= S_IDLE;
				end else begin
					res_alive_q <= fin_alive;
					res_oor_q   <= fin_oor;
					state_q     <= S_DONE;
				end
			end else if (state_q == S_STEP) begin
				step_cnt_q <= step_cnt_q + SCNT_W'(1);
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.alive_out    = rsp_alive_q;
	assign rsp.out_of_range = rsp_oor_q;

	// Row memory control. A cell access reads its row at the request transfer
	// and writes it back in the next cycle. During a step the sweep reads row
	// k in count k and writes back row k-STEP_LAG; rows beyond the grid read dead.
	always_comb begin
		store_ctl.rd_en   = accept;
		store_ctl.rd_zero = 1'b0;
		store_ctl.wr_en   = 1'b0;
		rd_addr           = ROW_W'(req.row_pos);
		wr_addr           = ROW_W'(step_cnt_q - SCNT_W'(STEP_LAG));
		wr_data           = next_row;
		cell_ctl.clear    = accept;
		cell_ctl.shift    = 1'b0;
		unique case (state_q)
			S_IDLE: ;
			S_RMW: begin
				store_ctl.wr_en = (type_q == REQ_WRITE) && inside_q;
				wr_addr         = row_q;
				wr_data         = rmw_row;
			end
			S_STEP: begin
				store_ctl.rd_en   = 1'b1;
				store_ctl.rd_zero = int'(step_cnt_q) >= int'(nrows);
				rd_addr           = ROW_W'(step_cnt_q);
				store_ctl.wr_en   = int'(step_cnt_q) >= STEP_LAG;
				cell_ctl.shift    = (step_cnt_q != '0)
					&& (int'(step_cnt_q) <= int'(nrows) + STEP_LAG - 2);
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// Row address of the pending cell access.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= ROW_W'(req.row_pos);
		end
	end

	always_comb begin
		rmw_row        = rd_data;
		rmw_row[col_q] = alive_q;
	end

	// Row of column cells; each hands its registered vertical sum to both
	// neighbors, and columns outside the grid in use keep their bits.
	for (genvar i = 0; i < MAX_COLS; i++) begin : g_col
		logic [1:0] left_sum;
		logic [1:0] right_sum;

		assign col_in_use[i] = i < int'(ncols);

		if (i == 0) begin : g_left_edge
			assign left_sum = 2'd0;
		end else begin : g_left
			assign left_sum = vsum[i-1];
		end

		if (i == MAX_COLS - 1) begin : g_right_edge
			assign right_sum = 2'd0;
		end else begin : g_right
			assign right_sum = vsum[i+1];
		end

		lge_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.in_use     (col_in_use[i]),
			.bit_in     (rd_data[i]),
			.vsum_left  (left_sum),
			.vsum_right (right_sum),
			.vsum       (vsum[i]),
			.next_bit   (next_row[i])
		);
	end

	lge_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (store_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

endmodule

[hw/rtl/lge_checker.sv]
// ----------------------------------------------------------------------------
// lge_checker: port-level checks for the life grid engine
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lge_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic alive_out,
	input logic out_of_range
);

	// A waiting response stays offered until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn before transfer");

	// A stalled response keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable({alive_out, out_of_range}))
		else $error("response payload changed while stalled");

	// An out-of-range access never reports a live cell.
	a_oor_dead: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(alive_out && out_of_range))
		else $error("live cell reported for an out-of-range access");

	// Every request leaves idle when it is taken, so ready drops after a transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is in progress");

endmodule

bind life_grid_generation_engine_unit lge_checker u_lge_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.alive_out    (rsp.alive_out),
	.out_of_range (rsp.out_of_range)
);

[test/life_grid_generation_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit_test: self-checking bench for the life engine
// A directed script runs first: reads after reset, corner and border cells, a
// blinker and a block across one generation, the unused request code, an
// empty grid and oversized size registers. Random phases follow, each under
// its own grid size, some with idle cycles on both sides. Each response is
// checked against a cell-level grid model in the bench or a typed-in response.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit_test;
	import lge_pkg::*;

	// The request code that no operation uses. It must still get a response.
	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

	// Life rule, counted over the eight neighbors only.
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_FEWEST = 2;

	localparam int DIRECTED_ROWS   = 27;
	localparam int RANDOM_PHASES   = 7;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int HOLD_CYCLES     = 250;
	// Longer than a full-grid generation, so this covers any
	// request still in flight after its response has been seen.
	localparam int DRAIN_CYCLES    = 80;
	localparam int MISMATCH_PRINTS = 10;

	typedef struct packed {
		logic [TYPE_W-1:0] code;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic              alive;
	} cell_request_t;

	typedef struct packed {
		logic alive;
		logic out_of_range;
	} cell_response_t;

	// One line of the directed script: either a size register write or a
	// request, with the response typed in where it is obvious.
	typedef struct packed {
		logic           size_write;
		cfg_reg_t       reg_idx;
		logic [CFG_W-1:0] reg_value;
		cell_request_t  request;
		logic           fixed;
		cell_response_t fixed_response;
	} script_line_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_data;

	lge_req_if req_ch ();
	lge_rsp_if rsp_ch ();

	life_grid_generation_engine_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #5 clk = ~clk;

	// Bench copy of the grid and of the two size registers.
	logic [MAX_COLS-1:0] cell_grid [MAX_ROWS];
	logic [CFG_W-1:0] grid_cols_reg;
	logic [CFG_W-1:0] grid_rows_reg;

	// Responses that the engine still owes, oldest first.
	cell_response_t awaited_responses [$];

	script_line_t directed_script [DIRECTED_ROWS];

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	logic hold_request    = 1'b0;
	logic hold_off;

	int requests_sent     = 0;
	int generations_sent  = 0;
	int responses_checked = 0;
	int size_settings     = 0;
	int mismatches        = 0;

	// ------------------------------------------------------------------------
	// Grid model
	// ------------------------------------------------------------------------

	// Size registers above the storage size count as the storage size.
	function automatic int in_use(input logic [CFG_W-1:0] value, input int limit);
		return (int'(value) > limit) ? limit : int'(value);
	endfunction

	// One synchronous generation over the grid in use. Cells outside it keep
	// their values and are never counted as neighbors.
	function automatic void advance_generation();
		logic [MAX_COLS-1:0] next_rows [MAX_ROWS];
		int nc;
		int nr;
		int live;
		nc = in_use(grid_cols_reg, MAX_COLS);
		nr = in_use(grid_rows_reg, MAX_ROWS);
		next_rows = cell_grid;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr &&
							c + dc >= 0 && c + dc < nc) begin
							live += int'(cell_grid[r + dr][c + dc]);
						end
					end
				end
				if (cell_grid[r][c]) begin
					next_rows[r][c] = (live == SURVIVE_FEWEST || live == BIRTH_COUNT);
				end else begin
					next_rows[r][c] = (live == BIRTH_COUNT);
				end
			end
		end
		cell_grid = next_rows;
	endfunction

	// Applies one request to the grid model and returns the response it owes.
	function automatic cell_response_t apply_cell_request(input cell_request_t rq);
		cell_response_t rsp;
		logic in_grid;
		rsp = '0;
		in_grid = int'(rq.col) < in_use(grid_cols_reg, MAX_COLS) &&
			int'(rq.row) < in_use(grid_rows_reg, MAX_ROWS);
		case (rq.code)
			REQ_WRITE: begin
				if (in_grid) begin
					cell_grid[rq.row][rq.col] = rq.alive;
				end else begin
					rsp.out_of_range = 1'b1;
				end
			end
			REQ_READ: begin
				if (in_grid) begin
					rsp.alive = cell_grid[rq.row][rq.col];
				end else begin
					rsp.out_of_range = 1'b1;
				end
			end
			REQ_STEP: begin
				advance_generation();
			end
			default: begin
			end
		endcase
		return rsp;
	endfunction

	// ------------------------------------------------------------------------
	// Script lines
	// ------------------------------------------------------------------------

	function automatic script_line_t checked_line(input logic [TYPE_W-1:0] code,
		input int col, input int row, input bit alive);
		script_line_t line;
		line = '0;
		line.request = '{code, POS_W'(col), POS_W'(row), alive};
		return line;
	endfunction

	function automatic script_line_t known_line(input logic [TYPE_W-1:0] code,
		input int col, input int row, input bit alive, input bit exp_alive,
		input bit exp_out_of_range);
		script_line_t line;
		line = checked_line(code, col, row, alive);
		line.fixed = 1'b1;
		line.fixed_response = '{exp_alive, exp_out_of_range};
		return line;
	endfunction

	function automatic script_line_t size_line(input cfg_reg_t idx, input int value);
		script_line_t line;
		line = '0;
		line.size_write = 1'b1;
		line.reg_idx = idx;
		line.reg_value = CFG_W'(value);
		return line;
	endfunction

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offers one request, with random idle cycles ahead of it, and waits for
	// the transfer. Called and returning at a rising edge.
	task automatic offer_request(input cell_request_t rq, input bit fixed,
		input cell_response_t fixed_response);
		int gap;
		cell_response_t predicted;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rq.code;
		req_ch.col_pos  <= rq.col;
		req_ch.row_pos  <= rq.row;
		req_ch.alive_in <= rq.alive;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		// The model moves with every accepted request, even when the script
		// gives the response by hand.
		predicted = apply_cell_request(rq);
		awaited_responses.push_back(fixed ? fixed_response : predicted);
		requests_sent++;
		if (rq.code == REQ_STEP) begin
			generations_sent++;
		end
	endtask

	// Drops valid and waits until the engine owes nothing. Every request gets
	// a response, so a short pause after the last one leaves the engine idle.
	task automatic wait_until_idle();
		req_ch.valid <= 1'b0;
		while (awaited_responses.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// One size register write. The extra edge keeps two writes in a row from
	// assigning the write enable twice in one time step.
	task automatic write_size_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COLS) begin
			grid_cols_reg = value;
		end else begin
			grid_rows_reg = value;
		end
		size_settings++;
		@(posedge clk);
	endtask

	// Random content, mostly aimed inside the grid in use so that patterns
	// build up and evolve; a tenth of the cell accesses go anywhere.
	function automatic cell_request_t random_request();
		cell_request_t rq;
		int pick;
		int nc;
		int nr;
		nc = in_use(grid_cols_reg, MAX_COLS);
		nr = in_use(grid_rows_reg, MAX_ROWS);
		pick = $urandom_range(99);
		rq.col = POS_W'($urandom_range(MAX_COLS - 1));
		rq.row = POS_W'($urandom_range(MAX_ROWS - 1));
		rq.alive = ($urandom_range(99) < 45);
		if (pick < 8) begin
			rq.code = REQ_STEP;
		end else if (pick < 10) begin
			rq.code = REQ_UNUSED;
		end else begin
			rq.code = (pick < 60) ? REQ_WRITE : REQ_READ;
			if (nc > 0 && nr > 0 && $urandom_range(9) != 0) begin
				rq.col = POS_W'($urandom_range(nc - 1));
				rq.row = POS_W'($urandom_range(nr - 1));
			end
		end
		return rq;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------------

	task automatic record_mismatch(input string what, input cell_response_t expected,
		input cell_response_t actual);
		mismatches++;
		if (mismatches <= MISMATCH_PRINTS) begin
			$display("%0t: %s: expected alive_out=%0b out_of_range=%0b, got alive_out=%0b out_of_range=%0b",
				$realtime, what, expected.alive, expected.out_of_range, actual.alive,
				actual.out_of_range);
		end
	endtask

	// Checks each response transfer against the oldest awaited one, then
	// picks ready for the next cycle. A long hold-off overrides the dice.
	initial begin
		cell_response_t actual;
		cell_response_t expected;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				actual = '{rsp_ch.alive_out, rsp_ch.out_of_range};
				responses_checked++;
				if (awaited_responses.size() == 0) begin
					record_mismatch("response with no request outstanding", '0, actual);
				end else begin
					expected = awaited_responses.pop_front();
					if (actual.alive !== expected.alive) begin
						record_mismatch("alive_out differs", expected, actual);
					end else if (actual.out_of_range !== expected.out_of_range) begin
						record_mismatch("out_of_range differs", expected, actual);
					end
				end
			end
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Long receiver hold-off: the sender keeps offering, the parked result
	// and the output register fill, and the engine has to stall its input.
	initial begin
		hold_off <= 1'b0;
		wait (hold_request === 1'b1);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		cell_request_t rq;
		int cols_value;
		int rows_value;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_idx         <= CFG_COLS;
		cfg_data        <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_WRITE;
		req_ch.col_pos  <= '0;
		req_ch.row_pos  <= '0;
		req_ch.alive_in <= 1'b0;

		for (int r = 0; r < MAX_ROWS; r++) begin
			cell_grid[r] = '0;
		end
		grid_cols_reg = CFG_RESET;
		grid_rows_reg = CFG_RESET;

		directed_script = '{
			// Everything is dead after reset, corners included.
			known_line(REQ_READ, 0, 0, 1'b0, 1'b0, 1'b0),
			known_line(REQ_READ, 63, 63, 1'b1, 1'b0, 1'b0),
			known_line(REQ_WRITE, 0, 0, 1'b1, 1'b0, 1'b0),
			checked_line(REQ_READ, 0, 0, 1'b0),
			// A block in the far corner should be stable across a step.
			checked_line(REQ_WRITE, 62, 62, 1'b1),
			checked_line(REQ_WRITE, 63, 62, 1'b1),
			checked_line(REQ_WRITE, 62, 63, 1'b1),
			checked_line(REQ_WRITE, 63, 63, 1'b1),
			// A blinker lying on the top border: the cell above is clipped off.
			checked_line(REQ_WRITE, 10, 0, 1'b1),
			checked_line(REQ_WRITE, 11, 0, 1'b1),
			checked_line(REQ_WRITE, 12, 0, 1'b1),
			known_line(REQ_STEP, 0, 0, 1'b0, 1'b0, 1'b0),
			checked_line(REQ_READ, 11, 1, 1'b0),
			checked_line(REQ_READ, 10, 0, 1'b0),
			checked_line(REQ_READ, 63, 63, 1'b0),
			known_line(REQ_UNUSED, 63, 63, 1'b1, 1'b0, 1'b0),
			// Empty grid: every access is out of range and a step is a no-op.
			size_line(CFG_COLS, 0),
			known_line(REQ_READ, 5, 5, 1'b0, 1'b0, 1'b1),
			known_line(REQ_WRITE, 5, 5, 1'b1, 1'b0, 1'b1),
			known_line(REQ_STEP, 0, 0, 1'b0, 1'b0, 1'b0),
			// Oversized column count clips to the storage width; three rows.
			size_line(CFG_COLS, 127),
			size_line(CFG_ROWS, 3),
			checked_line(REQ_WRITE, 63, 2, 1'b1),
			known_line(REQ_READ, 0, 3, 1'b0, 1'b0, 1'b1),
			known_line(REQ_STEP, 63, 63, 1'b1, 1'b0, 1'b0),
			checked_line(REQ_READ, 62, 62, 1'b0),
			checked_line(REQ_READ, 11, 0, 1'b0)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with both sides ready all the time.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_script[i].size_write) begin
				wait_until_idle();
				write_size_reg(directed_script[i].reg_idx, directed_script[i].reg_value);
			end else begin
				offer_request(directed_script[i].request, directed_script[i].fixed,
					directed_script[i].fixed_response);
			end
		end

		// Random phases. The first two idle the receiver hard, the next two
		// the sender, and the rest run without idling.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin cols_value = 64;  rows_value = 64; end
				1: begin cols_value = 8;   rows_value = 8;  end
				2: begin cols_value = 1;   rows_value = 1;  end
				3: begin cols_value = 127; rows_value = 65; end
				4: begin cols_value = 6;   rows_value = 40; end
				5: begin cols_value = 64;  rows_value = 2;  end
				default: begin
					cols_value = $urandom_range((1 << CFG_W) - 1);
					rows_value = $urandom_range((1 << CFG_W) - 1);
				end
			endcase
			if (p < 2) begin
				sender_idle_pct = 10;
				receiver_idle_pct = 70;
			end else if (p < 4) begin
				sender_idle_pct = 70;
				receiver_idle_pct = 10;
			end else begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			wait_until_idle();
			write_size_reg(CFG_COLS, CFG_W'(cols_value));
			write_size_reg(CFG_ROWS, CFG_W'(rows_value));
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Midway through a phase with a busy sender, the receiver
				// stops taking responses for a long stretch.
				if (p == 4 && i == 30) begin
					hold_request <= 1'b1;
				end
				rq = random_request();
				offer_request(rq, 1'b0, '0);
			end
		end

		wait_until_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses to %0d requests, %0d of them generation steps,",
			responses_checked, requests_sent, generations_sent);
		$display("across %0d size register writes including empty and oversized grids.",
			size_settings);
		if (mismatches == 0 && awaited_responses.size() == 0) begin
			$display("life_grid_generation_engine_unit: match");
		end else begin
			$display("life_grid_generation_engine_unit: mismatch");
		end
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("life_grid_generation_engine_unit: mismatch");
		$finish;
	end

endmodule

[life_grid_generation_engine_unit.f]
hw/rtl/lge_pkg.sv
hw/rtl/lge_req_if.sv
hw/rtl/lge_rsp_if.sv
hw/rtl/lge_cell.sv
hw/rtl/lge_store.sv
hw/rtl/life_grid_generation_engine_unit.sv
hw/rtl/lge_checker.sv
test/life_grid_generation_engine_unit_test.sv
